// ===== src/velocity_command_slew_limiter_macros.svh =====
// Assertion macros for the velocity command slew limiter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef VELOCITY_COMMAND_SLEW_LIMITER_MACROS_SVH
`define VELOCITY_COMMAND_SLEW_LIMITER_MACROS_SVH

// same-cycle implication
`define VCSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vcsl_pkg.sv =====
// Shared types and constants of the velocity command slew limiter.
// No dependencies; imported by every module of the block.
package vcsl_pkg;

  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_X,
    REG_MAX_Y,
    REG_MAX_TURN,
    REG_ACCEL,
    REG_DECEL,
    REG_TIMEOUT
  } cfg_reg_t;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic signed [15:0] cmd_turn;
    logic [15:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] speed_turn;
    logic               changed;
  } out_item_t;

  typedef struct packed {
    logic [14:0] max_speed_x;
    logic [14:0] max_speed_y;
    logic [14:0] max_speed_turn;
    logic [9:0]  accel_ratio;
    logic [9:0]  decel_ratio;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_BUSY,
    ST_FINISH
  } st_t;

endpackage

// ===== src/velocity_command_slew_limiter.sv =====
// Velocity command slew limiter top level: sequencer, datapath, output register.
// Depends on vcsl_pkg, vcsl_serial_mult and vcsl_cfg_regs.
//
// Input channel (in_valid/in_ready/in_data) carries either a velocity command
// or a timer tick. A command, or a tick that reaches the timeout, starts an
// update; a tick below the timeout only bumps the idle count and gives no
// result. Each update yields one result on out_valid/out_ready/out_data.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready, and are meant for idle periods only.
// An update runs eleven passes of one shared bit-serial multiplier, each pass
// a launch state and a busy state, then a finish state that loads the result;
// no new item is taken until the update is through. A tick with no update is
// absorbed while the block stays idle and ready.
// The result sits in an output register; the next input item is taken while
// it waits. If the receiver stalls, the following update holds its result
// in the final step and takes no new input until the register is free.
// Reset (rst, synchronous) clears the last outputs and the idle count, loads
// the default configuration and drops out_valid.
module velocity_command_slew_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vcsl_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vcsl_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vcsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcsl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vcsl_pkg::*;

  localparam logic [3:0] STEP_SCALE_X    = 4'd0;
  localparam logic [3:0] STEP_SCALE_Y    = 4'd1;
  localparam logic [3:0] STEP_SCALE_TURN = 4'd2;
  localparam logic [3:0] STEP_ROT_X      = 4'd3;
  localparam logic [3:0] STEP_ROT_Y      = 4'd4;
  localparam logic [3:0] STEP_RM_X       = 4'd5;
  localparam logic [3:0] STEP_LIM_X      = 4'd6;
  localparam logic [3:0] STEP_RM_Y       = 4'd7;
  localparam logic [3:0] STEP_LIM_Y      = 4'd8;
  localparam logic [3:0] STEP_RM_TURN    = 4'd9;
  localparam logic [3:0] STEP_LIM_TURN   = 4'd10;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_TURN = 2'd2;

  localparam logic [15:0] ROT_C = 16'd56756;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     mul_start;

  st_t        state;
  st_t        state_next;
  logic [3:0] step;

  logic signed [15:0] cmd [3];
  logic [15:0]        dt;
  logic signed [15:0] scaled [3];
  logic signed [32:0] cdx;
  logic signed [15:0] tgt [3];
  logic [24:0]        rm;
  logic [4:0]         lim [3];
  logic signed [15:0] last_speed [3];
  logic [15:0]        idle_ticks;
  logic signed [15:0] nv [3];

  logic        accept;
  logic [15:0] idle_inc;
  logic        tick_hit;
  logic        start_job;
  logic        out_free;
  logic        finish_load;
  logic        step_done;

  logic [1:0]         axis;
  logic signed [15:0] sel_cmd;
  logic signed [15:0] sel_scaled;
  logic signed [15:0] sel_tgt;
  logic signed [15:0] sel_prev;
  logic [14:0]        sel_maxs;
  logic [16:0]        abs_cmd;
  logic [16:0]        abs_scaled;
  logic [16:0]        abs_tgt;
  logic [16:0]        abs_prev;
  logic [9:0]         ratio_sel;

  logic signed [32:0] sp;
  logic signed [32:0] sr;
  logic signed [32:0] st;
  logic signed [32:0] maxs_s;
  logic signed [15:0] scale_res;
  logic signed [32:0] rot_s;
  logic signed [34:0] sx35;
  logic signed [34:0] sy35;
  logic signed [34:0] tx;
  logic signed [34:0] ty;
  logic signed [34:0] txs;
  logic signed [34:0] tys;
  logic signed [15:0] tx_c;
  logic signed [15:0] ty_c;

  vcsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vcsl_serial_mult u_mult (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  function automatic logic signed [15:0] slew_fn(input logic signed [15:0] prev,
                                                input logic signed [15:0] target,
                                                input logic [4:0] limit);
    logic [16:0] prev17;
    logic [16:0] err;
    logic [16:0] mag;
    logic [16:0] r;
    prev17 = {prev[15], prev};
    err    = {target[15], target} - prev17;
    mag    = err[16] ? (17'd0 - err) : err;
    if (mag > {12'd0, limit}) begin
      mag = {12'd0, limit};
    end
    r = err[16] ? (prev17 - mag) : (prev17 + mag);
    return r[15:0];
  endfunction

  // idle count and tick timeout
  assign idle_inc  = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
  assign tick_hit  = idle_inc >= cfg.timeout_ticks;
  assign start_job = (in_data.operation == OP_CMD) || tick_hit;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign step_done = (state == ST_BUSY) && mul_rsp.done;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && start_job) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_next = ST_BUSY;
      ST_BUSY: begin
        if (mul_rsp.done) begin
          state_next = (step == STEP_LIM_TURN) ? ST_FINISH : ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    mul_start   = 1'b0;
    finish_load = 1'b0;
    case (state)
      ST_IDLE:   in_ready    = 1'b1;
      ST_LAUNCH: mul_start   = 1'b1;
      ST_BUSY:   ;
      ST_FINISH: finish_load = out_free;
      default:   ;
    endcase
  end

  // axis picked by the current step
  always_comb begin
    case (step)
      STEP_SCALE_X, STEP_ROT_X, STEP_RM_X, STEP_LIM_X: axis = AX_X;
      STEP_SCALE_Y, STEP_ROT_Y, STEP_RM_Y, STEP_LIM_Y: axis = AX_Y;
      STEP_SCALE_TURN, STEP_RM_TURN, STEP_LIM_TURN:    axis = AX_TURN;
      default:                                         axis = AX_X;
    endcase
  end

  always_comb begin
    case (axis)
      AX_Y: begin
        sel_cmd    = cmd[1];
        sel_scaled = scaled[1];
        sel_tgt    = tgt[1];
        sel_prev   = last_speed[1];
        sel_maxs   = cfg.max_speed_y;
      end
      AX_TURN: begin
        sel_cmd    = cmd[2];
        sel_scaled = scaled[2];
        sel_tgt    = tgt[2];
        sel_prev   = last_speed[2];
        sel_maxs   = cfg.max_speed_turn;
      end
      default: begin
        sel_cmd    = cmd[0];
        sel_scaled = scaled[0];
        sel_tgt    = tgt[0];
        sel_prev   = last_speed[0];
        sel_maxs   = cfg.max_speed_x;
      end
    endcase
  end

  // operand selection; zero counts as positive for the regime test
  always_comb begin
    abs_cmd    = sel_cmd[15] ? (17'd0 - {1'b1, sel_cmd}) : {1'b0, sel_cmd};
    abs_scaled = sel_scaled[15] ? (17'd0 - {1'b1, sel_scaled}) : {1'b0, sel_scaled};
    abs_tgt    = sel_tgt[15] ? (17'd0 - {1'b1, sel_tgt}) : {1'b0, sel_tgt};
    abs_prev   = sel_prev[15] ? (17'd0 - {1'b1, sel_prev}) : {1'b0, sel_prev};
    ratio_sel  = ((sel_tgt[15] == sel_prev[15]) && (abs_tgt > abs_prev)) ?
                 cfg.accel_ratio : cfg.decel_ratio;
    mul_req.start = mul_start;
    case (step)
      STEP_SCALE_X, STEP_SCALE_Y, STEP_SCALE_TURN: begin
        mul_req.a = MUL_A_W'(sel_maxs);
        mul_req.b = abs_cmd;
      end
      STEP_ROT_X, STEP_ROT_Y: begin
        mul_req.a = MUL_A_W'(ROT_C);
        mul_req.b = abs_scaled;
      end
      STEP_RM_X, STEP_RM_Y, STEP_RM_TURN: begin
        mul_req.a = MUL_A_W'(sel_maxs);
        mul_req.b = MUL_B_W'(ratio_sel);
      end
      STEP_LIM_X, STEP_LIM_Y, STEP_LIM_TURN: begin
        mul_req.a = rm;
        mul_req.b = MUL_B_W'(dt);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // scale: round half up, clamp to full scale
  always_comb begin
    sp     = sel_cmd[15] ? -$signed({2'b00, mul_rsp.prod[30:0]})
                         : $signed({2'b00, mul_rsp.prod[30:0]});
    sr     = sp + 33'sd16384;
    st     = sr >>> 15;
    maxs_s = $signed({18'd0, sel_maxs});
    if (st > maxs_s) begin
      scale_res = maxs_s[15:0];
    end else if (st < -maxs_s) begin
      scale_res = 16'(-maxs_s);
    end else begin
      scale_res = st[15:0];
    end
  end

  // rotation: second product arrives in the Y step
  always_comb begin
    rot_s = sel_scaled[15] ? -$signed({2'b00, mul_rsp.prod[30:0]})
                           : $signed({2'b00, mul_rsp.prod[30:0]});
    sx35  = $signed({{19{scaled[0][15]}}, scaled[0]});
    sy35  = $signed({{19{scaled[1][15]}}, scaled[1]});
    tx    = $signed({{2{cdx[32]}}, cdx}) + (sy35 <<< 15) + 35'sd32768;
    ty    = (sx35 <<< 15) - $signed({{2{rot_s[32]}}, rot_s}) + 35'sd32768;
    txs   = tx >>> 16;
    tys   = ty >>> 16;
    if (txs > 35'sd32767) begin
      tx_c = 16'sh7FFF;
    end else if (txs < -35'sd32768) begin
      tx_c = 16'sh8000;
    end else begin
      tx_c = txs[15:0];
    end
    if (tys > 35'sd32767) begin
      ty_c = 16'sh7FFF;
    end else if (tys < -35'sd32768) begin
      ty_c = 16'sh8000;
    end else begin
      ty_c = tys[15:0];
    end
  end

  assign nv[0] = slew_fn(last_speed[0], tgt[0], lim[0]);
  assign nv[1] = slew_fn(last_speed[1], tgt[1], lim[1]);
  assign nv[2] = slew_fn(last_speed[2], tgt[2], lim[2]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= STEP_SCALE_X;
      idle_ticks    <= '0;
      last_speed[0] <= '0;
      last_speed[1] <= '0;
      last_speed[2] <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= STEP_SCALE_X;
        if (in_data.operation == OP_TICK) begin
          idle_ticks <= tick_hit ? 16'd0 : idle_inc;
        end else begin
          idle_ticks <= '0;
        end
      end
      if (step_done && (step != STEP_LIM_TURN)) begin
        step <= step + 4'd1;
      end
      if (finish_load) begin
        last_speed[0] <= nv[0];
        last_speed[1] <= nv[1];
        last_speed[2] <= nv[2];
        out_valid     <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd[0] <= (in_data.operation == OP_TICK) ? 16'sd0 : in_data.cmd_x;
      cmd[1] <= (in_data.operation == OP_TICK) ? 16'sd0 : in_data.cmd_y;
      cmd[2] <= (in_data.operation == OP_TICK) ? 16'sd0 : in_data.cmd_turn;
      dt     <= in_data.time_step;
    end
    if (step_done) begin
      case (step)
        STEP_SCALE_X: scaled[0] <= scale_res;
        STEP_SCALE_Y: scaled[1] <= scale_res;
        STEP_SCALE_TURN: begin
          scaled[2] <= scale_res;
          tgt[2]    <= scale_res;
        end
        STEP_ROT_X: cdx <= rot_s;
        STEP_ROT_Y: begin
          tgt[0] <= tx_c;
          tgt[1] <= ty_c;
        end
        STEP_RM_X, STEP_RM_Y, STEP_RM_TURN: rm <= mul_rsp.prod[24:0];
        STEP_LIM_X:    lim[0] <= mul_rsp.prod[40:36];
        STEP_LIM_Y:    lim[1] <= mul_rsp.prod[40:36];
        STEP_LIM_TURN: lim[2] <= mul_rsp.prod[40:36];
        default: ;
      endcase
    end
    if (finish_load) begin
      out_data.speed_x    <= nv[0];
      out_data.speed_y    <= nv[1];
      out_data.speed_turn <= nv[2];
      out_data.changed    <= (nv[0] != last_speed[0]) || (nv[1] != last_speed[1]) ||
                             (nv[2] != last_speed[2]);
    end
  end

endmodule

// ===== src/vcsl_serial_mult.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on vcsl_pkg for the request and response types.
module vcsl_serial_mult (
  input  logic               clk,
  input  logic               rst,
  input  vcsl_pkg::mul_req_t req,
  output vcsl_pkg::mul_rsp_t rsp
);
  import vcsl_pkg::*;

  logic [MUL_A_W-1:0]   a_reg;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W:0]     sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      hi    <= '0;
      lo    <= req.b;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi, lo};

endmodule

// ===== src/vcsl_cfg_regs.sv =====
// Configuration register file: full-scale speeds, slew ratios, timeout.
// Depends on vcsl_pkg for cfg_t and the port widths.
module vcsl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vcsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcsl_pkg::CFG_DATA_W-1:0] cfg_data,
  output vcsl_pkg::cfg_t                  cfg
);
  import vcsl_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed_x    <= 15'd4096;
      cfg.max_speed_y    <= 15'd4096;
      cfg.max_speed_turn <= 15'd4096;
      cfg.accel_ratio    <= 10'd77;
      cfg.decel_ratio    <= 10'd256;
      cfg.timeout_ticks  <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_X:    cfg.max_speed_x    <= cfg_data[14:0];
        REG_MAX_Y:    cfg.max_speed_y    <= cfg_data[14:0];
        REG_MAX_TURN: cfg.max_speed_turn <= cfg_data[14:0];
        REG_ACCEL:    cfg.accel_ratio    <= cfg_data[9:0];
        REG_DECEL:    cfg.decel_ratio    <= cfg_data[9:0];
        REG_TIMEOUT:  cfg.timeout_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/vcsl_checker.sv =====
// Port-level checker for the velocity command slew limiter, with its bind.
// Depends on vcsl_pkg and velocity_command_slew_limiter_macros.svh.
`include "velocity_command_slew_limiter_macros.svh"

module vcsl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input vcsl_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input vcsl_pkg::out_item_t out_data
);
  import vcsl_pkg::*;

  // stalled result holds
  `VCSL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // reset drops the result
  `VCSL_ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !out_valid, "out_valid high after reset")

  // a command transfer starts work, so input closes
  `VCSL_ASSERT_NEXT(a_cmd_busy, clk, rst, in_valid && in_ready && (in_data.operation == OP_CMD), !in_ready, "input still open after a command transfer")

  // a new result comes only out of the busy sequence
  `VCSL_ASSERT_NOW(a_out_from_busy, clk, rst, $rose(out_valid), $past(!in_ready), "result appeared without an update in flight")

endmodule

bind velocity_command_slew_limiter vcsl_checker u_vcsl_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the velocity command slew limiter.
// Needs vcsl_pkg and the RTL under src; holds its own bit-exact predictor of the block,
// drives items and results with random gaps and one long stall, registers back to back.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vcsl_pkg::*;

  localparam int      ITEMS_PER_PHASE = 150;
  localparam int      PHASES          = 8;
  localparam int      SETTLE_CYCLES   = 260;
  localparam int      STALL_LIMIT     = 20000;
  localparam int      HOLD_AT         = 60;
  localparam int      HOLD_CYCLES     = 3000;
  localparam longint ROT_COS         = 56756;
  localparam longint ROT_HALF        = 32768;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    idx;
    logic [15:0] val;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  cfg_t               limits;
  logic signed [15:0] shaped_speed [3];
  logic [15:0]        idle_count;

  out_item_t speeds_due [$];
  bit        no_gaps = 1'b0;
  int        mismatches = 0;
  int        results_checked = 0;
  int        commands_sent = 0;
  int        ticks_sent = 0;
  int        settings_used = 1;
  int        stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  velocity_command_slew_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // fraction times full scale, rounded half up, clamped to +-full scale
  function automatic longint scale_to_speed(input logic signed [15:0] frac,
                                            input logic [14:0] full);
    longint p;
    longint t;
    longint f;
    f = longint'({49'd0, full});
    p = longint'(frac) * f;
    t = (p + 16384) >>> 15;
    if (t > f) t = f;
    else if (t < -f) t = -f;
    return t;
  endfunction

  function automatic logic signed [15:0] slew_axis(input logic signed [15:0] prev,
                                                   input logic signed [15:0] goal,
                                                   input logic [14:0] full,
                                                   input logic [15:0] dt);
    longint p;
    longint g;
    longint err;
    longint mag;
    longint step_max;
    logic [9:0] ratio;
    p = prev;
    g = goal;
    if (((g < 0) == (p < 0)) && ((g < 0 ? -g : g) > (p < 0 ? -p : p)))
      ratio = limits.accel_ratio;
    else
      ratio = limits.decel_ratio;
    step_max = longint'((64'(ratio) * 64'(full) * 64'(dt)) >> 36);
    err = g - p;
    mag = err < 0 ? -err : err;
    if (mag > step_max) mag = step_max;
    return 16'(err < 0 ? p - mag : p + mag);
  endfunction

  // advances the predictor by one item; returns 1 when the item yields a result
  function automatic bit step_limiter(input in_item_t it, output out_item_t res);
    longint             dx;
    longint             dy;
    longint             dw;
    logic signed [15:0] goal [3];
    logic [14:0]        full [3];
    logic signed [15:0] nxt;
    bit                 moved;
    dx = 0;
    dy = 0;
    dw = 0;
    moved = 1'b0;
    res = '0;
    if (it.operation == OP_TICK) begin
      if (idle_count != 16'hFFFF) idle_count = idle_count + 16'd1;
      if (idle_count < limits.timeout_ticks) return 1'b0;
      idle_count = '0;
    end else begin
      idle_count = '0;
      dx = scale_to_speed(it.cmd_x, limits.max_speed_x);
      dy = scale_to_speed(it.cmd_y, limits.max_speed_y);
      dw = scale_to_speed(it.cmd_turn, limits.max_speed_turn);
    end
    goal[0] = sat16((ROT_COS * dx + ROT_HALF * dy + 32768) >>> 16);
    goal[1] = sat16((ROT_HALF * dx - ROT_COS * dy + 32768) >>> 16);
    goal[2] = 16'(dw);
    full[0] = limits.max_speed_x;
    full[1] = limits.max_speed_y;
    full[2] = limits.max_speed_turn;
    for (int i = 0; i < 3; i++) begin
      nxt = slew_axis(shaped_speed[i], goal[i], full[i], it.time_step);
      if (nxt != shaped_speed[i]) moved = 1'b1;
      shaped_speed[i] = nxt;
    end
    res.speed_x    = shaped_speed[0];
    res.speed_y    = shaped_speed[1];
    res.speed_turn = shaped_speed[2];
    res.changed    = moved;
    return 1'b1;
  endfunction

  function automatic row_t item_row(input logic op, input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] w, input logic [15:0] dt);
    row_t r;
    r.kind = ROW_ITEM;
    r.idx = REG_MAX_X;
    r.val = '0;
    r.item.operation = op;
    r.item.cmd_x = x;
    r.item.cmd_y = y;
    r.item.cmd_turn = w;
    r.item.time_step = dt;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t reg_row(input cfg_reg_t idx, input logic [15:0] val);
    row_t r;
    r = item_row(OP_CMD, '0, '0, '0, '0);
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [15:0] draw_frac();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // commands mostly follow the burst heading so the outputs can build up speed
  function automatic in_item_t draw_item(input in_item_t heading);
    in_item_t it;
    it = heading;
    it.operation = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_CMD;
    if ($urandom_range(0, 3) == 0) begin
      it.cmd_x = draw_frac();
      it.cmd_y = draw_frac();
      it.cmd_turn = draw_frac();
    end else begin
      it.cmd_x = heading.cmd_x ^ 16'($urandom_range(0, 31));
      it.cmd_y = heading.cmd_y ^ 16'($urandom_range(0, 31));
      it.cmd_turn = heading.cmd_turn ^ 16'($urandom_range(0, 31));
    end
    case ($urandom_range(0, 9))
      0: it.time_step = 16'h0000;
      1: it.time_step = 16'hFFFF;
      2, 3: it.time_step = 16'($urandom);
      default: it.time_step = 16'($urandom_range(32768, 65535));
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (cfg_valid) cfg_valid <= 1'b0;
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.operation == OP_TICK) ticks_sent++;
    else commands_sent++;
    if (step_limiter(it, res)) speeds_due.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_X:    limits.max_speed_x = val[14:0];
      REG_MAX_Y:    limits.max_speed_y = val[14:0];
      REG_MAX_TURN: limits.max_speed_turn = val[14:0];
      REG_ACCEL:    limits.accel_ratio = val[9:0];
      REG_DECEL:    limits.decel_ratio = val[9:0];
      REG_TIMEOUT:  limits.timeout_ticks = val;
      default: ;
    endcase
  endtask

  // a tick may still be in flight after the last result, so wait out the update latency
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    row_t     plan [$];
    row_t     r;
    in_item_t heading;
    cfg_t     pick;
    bit       prev_item;
    int       burst;
    int       sent;
    limits = '{max_speed_x: 15'd4096, max_speed_y: 15'd4096, max_speed_turn: 15'd4096,
               accel_ratio: 10'd77, decel_ratio: 10'd256, timeout_ticks: 16'd100};
    foreach (shaped_speed[i]) shaped_speed[i] = '0;
    idle_count = '0;
    prev_item = 1'b0;

    // defaults: the step limit rounds down to zero, a zero time step holds everything
    plan.push_back(item_row(OP_CMD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000));
    plan[plan.size() - 1].typed = 1'b1;
    plan.push_back(item_row(OP_CMD, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF));
    plan.push_back(item_row(OP_TICK, 16'h1234, 16'hEDCB, 16'h5A5A, 16'hFFFF));
    plan.push_back(reg_row(REG_MAX_X, 16'd32767));
    plan.push_back(reg_row(REG_MAX_Y, 16'd32767));
    plan.push_back(reg_row(REG_MAX_TURN, 16'd32767));
    plan.push_back(reg_row(REG_ACCEL, 16'd1023));
    plan.push_back(reg_row(REG_DECEL, 16'd1023));
    plan.push_back(reg_row(REG_TIMEOUT, 16'd1));
    // zero command from rest stays at rest
    plan.push_back(item_row(OP_CMD, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    plan[plan.size() - 1].typed = 1'b1;
    plan.push_back(item_row(OP_CMD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    plan.push_back(item_row(OP_CMD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    plan.push_back(item_row(OP_CMD, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    plan.push_back(item_row(OP_CMD, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
    plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    plan.push_back(reg_row(REG_TIMEOUT, 16'd0));
    plan.push_back(item_row(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000));
    plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    plan.push_back(reg_row(REG_ACCEL, 16'd0));
    plan.push_back(item_row(OP_CMD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF));
    plan.push_back(reg_row(REG_MAX_TURN, 16'd0));
    plan.push_back(item_row(OP_CMD, 16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_REG) begin
        if (prev_item) begin
          settle();
          settings_used++;
        end
        write_reg(r.idx, r.val);
        prev_item = 1'b0;
      end else begin
        send_item(r.item, r.typed, r.want);
        prev_item = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      settings_used++;
      no_gaps = (ph == 2);
      if (ph == 0) begin
        pick = '{max_speed_x: '0, max_speed_y: '0, max_speed_turn: '0,
                 accel_ratio: '0, decel_ratio: '0, timeout_ticks: 16'hFFFF};
      end else begin
        pick.max_speed_x = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                       : 15'($urandom_range(24576, 32767));
        pick.max_speed_y = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                       : 15'($urandom_range(24576, 32767));
        pick.max_speed_turn = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                          : 15'($urandom_range(24576, 32767));
        pick.accel_ratio = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                       : 10'($urandom_range(768, 1023));
        pick.decel_ratio = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                       : 10'($urandom_range(768, 1023));
        case ($urandom_range(0, 3))
          0: pick.timeout_ticks = 16'd0;
          1: pick.timeout_ticks = 16'd1;
          2: pick.timeout_ticks = 16'($urandom_range(2, 6));
          default: pick.timeout_ticks = 16'($urandom_range(7, 65535));
        endcase
      end
      write_reg(REG_MAX_X, 16'(pick.max_speed_x));
      write_reg(REG_MAX_Y, 16'(pick.max_speed_y));
      write_reg(REG_MAX_TURN, 16'(pick.max_speed_turn));
      write_reg(REG_ACCEL, 16'(pick.accel_ratio));
      write_reg(REG_DECEL, 16'(pick.decel_ratio));
      write_reg(REG_TIMEOUT, pick.timeout_ticks);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        heading.operation = OP_CMD;
        heading.cmd_x = draw_frac();
        heading.cmd_y = draw_frac();
        heading.cmd_turn = draw_frac();
        heading.time_step = 16'hFFFF;
        burst = $urandom_range(4, 24);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          send_item(draw_item(heading), 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    $display("covered %0d commands and %0d ticks under %0d register settings",
             commands_sent, ticks_sent, settings_used);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[velocity_command_slew_limiter] OK");
    end else begin
      $display("[velocity_command_slew_limiter] ERROR");
    end
    $finish;
  end

  // result side: random back-pressure, one long hold so the block backs up
  initial begin : receiver
    int wait_cycles;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
      else wait_cycles = no_gaps ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        if (out_ready) out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (speeds_due.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        want = speeds_due.pop_front();
        results_checked++;
        if (out_data.speed_x !== want.speed_x) begin
          $error("speed_x: expected %0d, got %0d", want.speed_x, out_data.speed_x);
          mismatches++;
        end
        if (out_data.speed_y !== want.speed_y) begin
          $error("speed_y: expected %0d, got %0d", want.speed_y, out_data.speed_y);
          mismatches++;
        end
        if (out_data.speed_turn !== want.speed_turn) begin
          $error("speed_turn: expected %0d, got %0d", want.speed_turn, out_data.speed_turn);
          mismatches++;
        end
        if (out_data.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, out_data.changed);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, speeds_due.size());
      $display("[velocity_command_slew_limiter] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+src
src/vcsl_pkg.sv
src/vcsl_serial_mult.sv
src/vcsl_cfg_regs.sv
src/velocity_command_slew_limiter.sv
src/vcsl_checker.sv
test/testbench.sv
